/* rtl/core/ksb_pkg.sv */
// ----------------------------------------------------------------------------
// ksb_pkg
// Shared types, codes and default sizes for the k-stacks shared buffer core.
// ----------------------------------------------------------------------------
`default_nettype none

package ksb_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_NUM_STACKS = 4;
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // fixed port widths
  localparam int SID_W = 2;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;

  // operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // result status codes
  localparam logic [STS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STAT_EMPTY = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_WB
  } ksb_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic push_commit;
    logic pop_read;
    logic pop_commit;
    logic load_out;
  } ksb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_ok;
  } ksb_sts_t;

endpackage

`default_nettype wire

/* rtl/core/ksb_ctrl.sv */
// ----------------------------------------------------------------------------
// ksb_ctrl
// Sequencer for push and pop transactions and owner of the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ksb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  input  logic              out_stall,
  input  ksb_pkg::ksb_sts_t sts,
  output logic              in_stall,
  output logic              out_valid,
  output ksb_pkg::ksb_cmd_t cmd
);
  import ksb_pkg::*;

  ksb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take a new transaction
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == FUNC_POP) ? S_POP_RD : S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_POP_RD: begin
        state_nxt = S_POP_WB;
      end
      S_POP_WB: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_PUSH: begin
        cmd.push_commit = out_free && sts.op_ok;
        cmd.load_out    = out_free;
      end
      S_POP_RD: begin
        cmd.pop_read = sts.op_ok;
      end
      S_POP_WB: begin
        cmd.pop_commit = out_free && sts.op_ok;
        cmd.load_out   = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/ksb_datapath.sv */
// ----------------------------------------------------------------------------
// ksb_datapath
// Entry store, link store, stack top store, free list head and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksb_datapath #(
  parameter int NUM_STACKS = ksb_pkg::DEF_NUM_STACKS,
  parameter int ENTRIES    = ksb_pkg::DEF_ENTRIES,
  parameter int DATA_WIDTH = ksb_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ksb_pkg::ksb_cmd_t                cmd,
  output ksb_pkg::ksb_sts_t                sts,
  input  logic                             in_func,
  input  logic [ksb_pkg::SID_W-1:0]        in_stack_id,
  input  logic signed [ksb_pkg::VAL_W-1:0] in_push_value,
  output logic signed [ksb_pkg::VAL_W-1:0] out_pop_value,
  output logic [ksb_pkg::STS_W-1:0]        out_status
);
  import ksb_pkg::*;

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0]         PTR_NULL = PW'(ENTRIES);
  localparam logic [DATA_WIDTH-1:0] DATA_MIN = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

  // storage
  logic [DATA_WIDTH-1:0] data_mem [ENTRIES];
  logic [PW-1:0]         link_mem [ENTRIES];
  logic [PW-1:0]         top_mem  [NUM_STACKS];

  // transaction registers
  logic                  func_r;
  logic [SW-1:0]         sid_r;
  logic                  sid_ok_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [PW-1:0]         top_rd_r;
  logic                  top_hit_r;
  logic [PW-1:0]         link_rd_r;
  logic [PW-1:0]         link_addr_r;
  logic                  link_fresh_r;
  logic [DATA_WIDTH-1:0] data_rd_r;
  logic signed [VAL_W-1:0] out_pop_value_r;
  logic [STS_W-1:0]      out_status_r;

  // list state
  logic [PW-1:0]         free_head_r, free_head_nxt;
  logic [PW-1:0]         hwm_r, hwm_nxt;
  logic [NUM_STACKS-1:0] top_vld_r, top_vld_nxt;

  logic [SW-1:0]         sid_idx;
  logic                  sid_in_ok;
  logic [PW-1:0]         top_ptr;
  logic [PW-1:0]         link_next;
  logic                  push_ok;
  logic                  pop_ok;
  logic [PW-1:0]         rd_addr;
  logic                  link_we;
  logic [PW-1:0]         link_waddr;
  logic [PW-1:0]         link_wdata;
  logic                  top_we;
  logic [PW-1:0]         top_wdata;

  assign sid_idx   = SW'(in_stack_id);
  assign sid_in_ok = (int'(in_stack_id) < NUM_STACKS);

  // current top of the addressed stack, null until first written
  assign top_ptr = top_hit_r ? top_rd_r : PTR_NULL;

  // entries at or above the fill mark still hold their reset link i+1
  assign link_next = link_fresh_r ? (link_addr_r + PW'(1)) : link_rd_r;

  assign push_ok    = sid_ok_r && (free_head_r < PTR_NULL);
  assign pop_ok     = sid_ok_r && (top_ptr < PTR_NULL);
  assign sts.op_ok  = (func_r == FUNC_POP) ? pop_ok : push_ok;

  // latch the transaction and read the stack top
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r    <= in_func;
      sid_r     <= sid_idx;
      sid_ok_r  <= sid_in_ok;
      value_r   <= DATA_WIDTH'(in_push_value);
      top_rd_r  <= top_mem[sid_idx];
      top_hit_r <= top_vld_r[sid_idx];
    end
    if (top_we) begin
      top_mem[sid_r] <= top_wdata;
    end
  end

  // link store ports
  assign rd_addr    = cmd.accept ? free_head_r : top_ptr;
  assign link_we    = cmd.push_commit || cmd.pop_read;
  assign link_waddr = cmd.push_commit ? free_head_r : top_ptr;
  assign link_wdata = cmd.push_commit ? top_ptr : free_head_r;

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.pop_read) begin
      link_rd_r    <= link_mem[rd_addr[AW-1:0]];
      link_addr_r  <= rd_addr;
      link_fresh_r <= (rd_addr >= hwm_r);
    end
    if (link_we) begin
      link_mem[link_waddr[AW-1:0]] <= link_wdata;
    end
  end

  // entry store ports
  always_ff @(posedge clk) begin
    if (cmd.pop_read) begin
      data_rd_r <= data_mem[top_ptr[AW-1:0]];
    end
    if (cmd.push_commit) begin
      data_mem[free_head_r[AW-1:0]] <= value_r;
    end
  end

  // stack top write back
  assign top_we    = cmd.push_commit || cmd.pop_commit;
  assign top_wdata = cmd.push_commit ? free_head_r : link_next;

  // free list head, fill mark and top valid bits
  always_comb begin
    free_head_nxt = free_head_r;
    hwm_nxt       = hwm_r;
    top_vld_nxt   = top_vld_r;
    if (cmd.push_commit) begin
      free_head_nxt = link_next;
      if (free_head_r >= hwm_r) begin
        hwm_nxt = free_head_r + PW'(1);
      end
    end else if (cmd.pop_read) begin
      free_head_nxt = top_ptr;
    end
    if (top_we) begin
      top_vld_nxt[sid_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      hwm_r       <= '0;
      top_vld_r   <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      hwm_r       <= hwm_nxt;
      top_vld_r   <= top_vld_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (func_r == FUNC_PUSH) begin
        out_pop_value_r <= '0;
        out_status_r    <= push_ok ? STAT_OK : STAT_FULL;
      end else if (pop_ok) begin
        out_pop_value_r <= VAL_W'($signed(data_rd_r));
        out_status_r    <= STAT_OK;
      end else begin
        out_pop_value_r <= VAL_W'($signed(DATA_MIN));
        out_status_r    <= STAT_EMPTY;
      end
    end
  end

  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

/* rtl/core/k_stacks_shared_buffer_core.sv */
// ----------------------------------------------------------------------------
// k_stacks_shared_buffer_core
// Several LIFO stacks sharing one entry store through a linked free list.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. A push reads the stack top, then
// writes the link, entry and top; a pop reads the stack top, then the
// dependent link and entry, before the new top is written back. The result
// sits in an output register, and the next transaction is accepted while it
// waits to be taken. A push into a full store is dropped with status full
// and value zero; a pop from an empty stack returns the most negative value
// with status empty. There is no clearing pass after reset: a fill mark
// supplies the reset links of entries never used, and valid bits cover the
// stack tops.
`default_nettype none

module k_stacks_shared_buffer_core #(
  parameter int NUM_STACKS = ksb_pkg::DEF_NUM_STACKS,
  parameter int ENTRIES    = ksb_pkg::DEF_ENTRIES,
  parameter int DATA_WIDTH = ksb_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [ksb_pkg::SID_W-1:0]        in_stack_id,
  input  logic signed [ksb_pkg::VAL_W-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ksb_pkg::VAL_W-1:0] out_pop_value,
  output logic [ksb_pkg::STS_W-1:0]        out_status
);
  import ksb_pkg::*;

  ksb_cmd_t cmd;
  ksb_sts_t sts;

  // sequencer
  ksb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // stores and result register
  ksb_datapath #(
    .NUM_STACKS (NUM_STACKS),
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_stack_id   (in_stack_id),
    .in_push_value (in_push_value),
    .out_pop_value (out_pop_value),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

/* rtl/core/ksb_checker.sv */
// ----------------------------------------------------------------------------
// ksb_checker
// Port level checks for the k-stacks shared buffer core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ksb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [ksb_pkg::VAL_W-1:0] out_pop_value,
  input logic [ksb_pkg::STS_W-1:0]        out_status
);
  import ksb_pkg::*;

  // one transaction at a time: an accepted transaction blocks the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after an accepted transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pop_value) && $stable(out_status)))
    else $error("stalled result changed");

  // a dropped push reports value zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (out_pop_value == '0))
    else $error("full status with nonzero value");

  // a new result only appears as the core returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while a transaction is still in work");

endmodule

bind k_stacks_shared_buffer_core ksb_checker u_ksb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pop_value (out_pop_value),
  .out_status    (out_status)
);

`default_nettype wire

/* verif/k_stacks_shared_buffer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_stacks_shared_buffer_checker
// Watches both channels of the shared-buffer stack core. It keeps its own copy
// of the stacks and the free list and predicts the result of each accepted
// operation. Each result taken from the core is checked in order.
// ----------------------------------------------------------------------------
module k_stacks_shared_buffer_checker
  import ksb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_func,
  input  logic [SID_W-1:0]        in_stack_id,
  input  logic signed [VAL_W-1:0] in_push_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [VAL_W-1:0] out_pop_value,
  input  logic [STS_W-1:0]        out_status,
  output int                      fail_count,
  output int                      pending_count
);

  localparam int NUM_STACKS = DEF_NUM_STACKS;
  localparam int ENTRIES    = DEF_ENTRIES;
  localparam int PTR_W      = $clog2(ENTRIES + 1);
  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(ENTRIES);
  localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STS_W-1:0]        status;
  } stack_result_t;

  // shadow copy of the shared store
  logic signed [VAL_W-1:0] entry_data [ENTRIES];
  logic [PTR_W-1:0]        entry_link [ENTRIES];
  logic [PTR_W-1:0]        top_ptr [NUM_STACKS];
  logic [PTR_W-1:0]        free_ptr;

  stack_result_t awaited_results[$];
  int            result_index;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_index  = 0;
  end

  // empty stacks, every entry chained on the free list
  task automatic clear_stacks();
    for (int i = 0; i < ENTRIES; i++) begin
      entry_link[i] = (i == ENTRIES - 1) ? PTR_NULL : PTR_W'(i + 1);
      entry_data[i] = '0;
    end
    for (int s = 0; s < NUM_STACKS; s++) top_ptr[s] = PTR_NULL;
    free_ptr = '0;
  endtask

  // apply one push or pop to the shadow store and return its result
  function automatic stack_result_t apply_stack_op(logic func, logic [SID_W-1:0] sid,
                                                   logic signed [VAL_W-1:0] value);
    stack_result_t    res;
    logic [PTR_W-1:0] e;
    res.value  = '0;
    res.status = STAT_OK;
    if (func == FUNC_PUSH) begin
      if (sid >= NUM_STACKS || free_ptr >= ENTRIES) begin
        res.status = STAT_FULL;
      end else begin
        e             = free_ptr;
        free_ptr      = entry_link[e];
        entry_link[e] = top_ptr[sid];
        top_ptr[sid]  = e;
        entry_data[e] = value;
      end
    end else begin
      if (sid >= NUM_STACKS || top_ptr[sid] >= ENTRIES) begin
        res.status = STAT_EMPTY;
        res.value  = MOST_NEG;
      end else begin
        e             = top_ptr[sid];
        top_ptr[sid]  = entry_link[e];
        entry_link[e] = free_ptr;
        free_ptr      = e;
        res.value     = entry_data[e];
      end
    end
    return res;
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      clear_stacks();
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_stack_op(in_func, in_stack_id, in_push_value));
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with none outstanding: value %0d status %0d",
                     result_index, out_pop_value, out_status);
        end else begin
          want = awaited_results.pop_front();
          if (out_pop_value !== want.value || out_status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected value %0d status %0d, got value %0d status %0d",
                       result_index, want.value, want.status, out_pop_value, out_status);
          end
        end
        result_index++;
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

/* verif/k_stacks_shared_buffer_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_stacks_shared_buffer_core_test
// Drives pushes and pops into the shared-buffer stack core: a directed
// opening over empty stacks, value extremes and a full store, then bursts
// of random operations with a varying push share so the store keeps filling
// and draining. Both channels idle at random outside one steady stretch.
// ----------------------------------------------------------------------------
module k_stacks_shared_buffer_core_test;
  import ksb_pkg::*;

  localparam int RANDOM_OPS  = 650;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_func;
  logic [SID_W-1:0] in_stack_id;
  logic signed [VAL_W-1:0] in_push_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_pop_value;
  logic [STS_W-1:0] out_status;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  bit steady = 1'b0;

  k_stacks_shared_buffer_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_stack_id   (in_stack_id),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pop_value (out_pop_value),
    .out_status    (out_status)
  );

  k_stacks_shared_buffer_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_stack_id   (in_stack_id),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 14);
  end

  // present one transaction and hold it until taken
  task automatic issue_op(logic func, logic [SID_W-1:0] sid, logic signed [VAL_W-1:0] value);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_stack_id   <= sid;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int push_pct;
    int op_idx;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FUNC_PUSH;
    in_stack_id   <= '0;
    in_push_value <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // underflow on every stack
    for (int s = 0; s < DEF_NUM_STACKS; s++) issue_op(FUNC_POP, SID_W'(s), '0);
    // value extremes, two of them popped straight back
    issue_op(FUNC_PUSH, 2'd0, {1'b1, {(VAL_W-1){1'b0}}});
    issue_op(FUNC_PUSH, 2'd1, {1'b0, {(VAL_W-1){1'b1}}});
    issue_op(FUNC_PUSH, 2'd2, '0);
    issue_op(FUNC_PUSH, 2'd3, '1);
    issue_op(FUNC_POP, 2'd0, '0);
    issue_op(FUNC_POP, 2'd1, '0);
    // fill the store, then one push too many
    for (int i = 0; i < DEF_ENTRIES - 2; i++)
      issue_op(FUNC_PUSH, SID_W'(i % DEF_NUM_STACKS), $urandom);
    issue_op(FUNC_PUSH, 2'd1, $urandom);

    // random bursts, each with its own push share
    op_idx = 0;
    while (op_idx < RANDOM_OPS) begin
      case ($urandom_range(3))
        0:       push_pct = 15;
        1:       push_pct = 50;
        2:       push_pct = 85;
        default: push_pct = $urandom_range(100);
      endcase
      repeat ($urandom_range(10, 40)) begin
        steady = (op_idx >= 250 && op_idx < 400);
        if ($urandom_range(99) < push_pct)
          issue_op(FUNC_PUSH, SID_W'($urandom_range(DEF_NUM_STACKS - 1)), pick_value());
        else
          issue_op(FUNC_POP, SID_W'($urandom_range(DEF_NUM_STACKS - 1)), $urandom);
        op_idx++;
      end
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // drain
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ksb_pkg.sv
rtl/core/ksb_ctrl.sv
rtl/core/ksb_datapath.sv
rtl/core/k_stacks_shared_buffer_core.sv
rtl/core/ksb_checker.sv
verif/k_stacks_shared_buffer_checker.sv
verif/k_stacks_shared_buffer_core_test.sv
